### hdl/dip_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the decimal entry parser
// no dependencies; imported by every module of the block
package dip_pkg;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	localparam int VALUE_W = 32;
	localparam int DIGIT_W = 4;

	// limits on the value before a digit is appended, truncating toward zero
	localparam logic signed [VALUE_W-1:0] POS_LIMIT_LO = 32'sd214748364;
	localparam logic signed [VALUE_W-1:0] POS_LIMIT_HI = 32'sd214748363;
	localparam logic signed [VALUE_W-1:0] NEG_LIMIT_LO = -32'sd214748364;
	localparam logic signed [VALUE_W-1:0] NEG_LIMIT_HI = -32'sd214748363;
	localparam logic [DIGIT_W-1:0] DIGIT_EIGHT = 4'd8;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 4'd9;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_DIGIT,
		KIND_CR,
		KIND_MINUS,
		KIND_OTHER
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [DIGIT_W-1:0]  digit;
	} item_t;

endpackage

### hdl/dip_front.sv
`timescale 1ns / 1ps
// front end: takes input bytes and classifies them into kind and digit
// depends on dip_pkg
module dip_front import dip_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        q_full,
	output logic        q_push,
	output item_t       q_item
);

	logic [7:0] digit_raw;

	assign s_tready  = !q_full;
	assign q_push    = s_tvalid && !q_full;
	assign digit_raw = s_tdata - CH_ZERO;

	always_comb begin
		q_item.digit = digit_raw[DIGIT_W-1:0];
		if (s_tdata == CH_CR) begin
			q_item.kind = KIND_CR;
		end else if (s_tdata == CH_MINUS) begin
			q_item.kind = KIND_MINUS;
		end else if (s_tdata inside {[CH_ZERO:CH_NINE]}) begin
			q_item.kind = KIND_DIGIT;
		end else begin
			q_item.kind = KIND_OTHER;
		end
	end

endmodule

### hdl/dip_queue.sv
`timescale 1ns / 1ps
// short queue of classified bytes between front and back
// depends on dip_pkg
module dip_queue import dip_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t head
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/dip_back.sv
`timescale 1ns / 1ps
// back end: accumulator, sign and validity tracking, registered result output
// depends on dip_pkg
module dip_back import dip_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  item_t               q_head,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [VALUE_W-1:0]  m_tdata,   // [31:0] entered_value
	output logic                m_tuser    // [0] entry_ok
);

	logic [VALUE_W-1:0] accum_q;
	logic               neg_q;
	logic               valid_q;
	logic               lead_zero_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_ok_q;

	logic               out_free;
	logic               take;
	logic               accum_zero;
	logic [VALUE_W-1:0] digit_ext;
	logic [VALUE_W-1:0] times_ten;
	logic [VALUE_W-1:0] next_accum;
	logic signed [VALUE_W-1:0] limit;
	logic               overflow;

	assign out_free   = !out_valid_q || m_tready;
	assign q_pop      = q_not_empty && (q_head.kind != KIND_CR || out_free);
	assign take       = q_pop;
	assign accum_zero = (accum_q == '0);
	assign digit_ext  = VALUE_W'(q_head.digit);
	assign times_ten  = (accum_q << 3) + (accum_q << 1);
	assign next_accum = neg_q ? times_ten - digit_ext : times_ten + digit_ext;

	always_comb begin
		if (!neg_q) begin
			limit    = (q_head.digit >= DIGIT_EIGHT) ? POS_LIMIT_HI : POS_LIMIT_LO;
			overflow = $signed(accum_q) > limit;
		end else begin
			limit    = (q_head.digit == DIGIT_NINE) ? NEG_LIMIT_HI : NEG_LIMIT_LO;
			overflow = $signed(accum_q) < limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			neg_q       <= 1'b0;
			valid_q     <= 1'b1;
			lead_zero_q <= 1'b0;
		end else if (take) begin
			if (q_head.kind == KIND_CR) begin
				accum_q     <= '0;
				neg_q       <= 1'b0;
				valid_q     <= 1'b1;
				lead_zero_q <= 1'b0;
			end else if (accum_zero && q_head.kind == KIND_DIGIT && q_head.digit == '0) begin
				// a zero while nothing is accumulated counts even on a spoiled entry
				lead_zero_q <= 1'b1;
			end else if (valid_q) begin
				if (q_head.kind == KIND_MINUS && accum_zero && !lead_zero_q) begin
					neg_q <= 1'b1;
				end else if (q_head.kind != KIND_DIGIT || lead_zero_q || overflow) begin
					valid_q <= 1'b0;
				end else begin
					accum_q <= next_accum;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && q_head.kind == KIND_CR) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_head.kind == KIND_CR) begin
			out_value_q <= valid_q ? accum_q : '0;
			out_ok_q    <= valid_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_ok_q;

endmodule

### hdl/decimal_int32_entry_parser.sv
`timescale 1ns / 1ps
// Decimal entry parser, top level.
// Input stream s_*: one ASCII byte per request in s_tdata. Digits build a
// signed 32-bit value most significant first; a leading '-' makes it
// negative; a carriage return ends the entry. Any other byte, a nonzero
// digit after a leading zero, or an int32 overflow spoils the entry.
// Output stream m_*: one request per carriage return, m_tdata the value
// (zero when spoiled) and m_tuser the valid flag.
// Throughput: one byte per cycle while the queue is not full. The front
// end classifies the byte into a two-entry queue; the back end updates
// the accumulator (one times-ten add and limit compare) and loads the
// output register. An accepted carriage return is written into the queue,
// then popped into the output register, which drives m_tvalid.
// Stall: while a result waits in the output register, non-return bytes
// keep flowing; a second return waits in the queue and s_tready drops
// once the queue is full.
// Reset: accumulator cleared, sign positive, entry valid, queue empty.
// depends on dip_pkg, dip_front, dip_queue, dip_back
module decimal_int32_entry_parser import dip_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] char_in
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [VALUE_W-1:0]  m_tdata,   // [31:0] entered_value
	output logic                m_tuser    // [0] entry_ok
);

	logic  q_full;
	logic  q_push;
	item_t q_item;
	logic  q_pop;
	logic  q_not_empty;
	item_t q_head;

	dip_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	dip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	dip_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule
